// ===== rtl/keyframe_linear_interpolator_core_assert.svh =====
// assertion macros shared by the checking code
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define KLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kli_pkg.sv =====
package kli_pkg;

  localparam int MAX_KEYS = 32;
  localparam int AW       = $clog2(MAX_KEYS);
  localparam int CW       = $clog2(MAX_KEYS + 1);
  localparam int CNT_W    = 6;
  localparam int IDX_W    = 5;
  localparam int TW       = 16;
  localparam int VW       = 16;
  localparam int MW       = VW + TW;
  localparam int NCH      = 3;
  localparam int DCW      = $clog2(VW + 1);
  localparam int QDEPTH   = 2;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QCW      = $clog2(QDEPTH + 1);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] STATUS_INTERP = 2'd0;
  localparam logic [1:0] STATUS_LOW    = 2'd1;
  localparam logic [1:0] STATUS_HIGH   = 2'd2;
  localparam logic [1:0] STATUS_EMPTY  = 2'd3;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] entry_index;
    logic [TW-1:0]    key_time;
    logic [VW-1:0]    key_x;
    logic [VW-1:0]    key_y;
    logic [VW-1:0]    key_z;
    logic [TW-1:0]    query_time;
  } item_t;

  typedef struct packed {
    logic [VW-1:0] out_x;
    logic [VW-1:0] out_y;
    logic [VW-1:0] out_z;
    logic [1:0]    status;
  } res_t;

  // one keyframe as stored, lane 0 is x
  typedef struct packed {
    logic [TW-1:0]           t;
    logic [NCH-1:0][VW-1:0]  v;
  } entry_t;

  typedef struct packed {
    logic                    kind;
    logic [AW-1:0]           addr;
    logic [TW-1:0]           t;
    logic [NCH-1:0][VW-1:0]  v;
  } cmd_t;

  typedef struct packed {
    logic                    start;
    logic [TW-1:0]           den;
    logic [NCH-1:0][MW-1:0]  mag;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [NCH-1:0][VW-1:0]  quot;
  } div_rsp_t;

endpackage

// ===== rtl/kli_ram.sv =====
module kli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kli_front.sv =====
module kli_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  kli_pkg::item_t item,
  output logic           q_valid,
  input  logic           q_pop,
  output kli_pkg::cmd_t  q_cmd
);
  import kli_pkg::*;

  cmd_t            slot [QDEPTH];
  cmd_t            cmd;
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QCW-1:0]  count;
  logic            accept;
  logic            keep;
  logic            push;

  // classify: queries carry the query time, writes outside the table are dropped
  always_comb begin
    cmd.kind = item.mode;
    cmd.addr = AW'(item.entry_index);
    cmd.t    = (item.mode == MODE_QUERY) ? item.query_time : item.key_time;
    cmd.v[0] = item.key_x;
    cmd.v[1] = item.key_y;
    cmd.v[2] = item.key_z;
    keep     = (item.mode == MODE_QUERY) || (32'(item.entry_index) < MAX_KEYS);
  end

  assign item_stall = (count == QCW'(QDEPTH));
  assign accept     = item_valid && !item_stall;
  assign push       = accept && keep;
  assign q_valid    = (count != '0);
  assign q_cmd      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= cmd;
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/kli_div.sv =====
module kli_div (
  input  logic              clk,
  input  logic              rst,
  input  kli_pkg::div_req_t req,
  output kli_pkg::div_rsp_t rsp
);
  import kli_pkg::*;

  logic                    busy;
  logic                    done;
  logic [DCW-1:0]          cnt;
  logic [TW-1:0]           den_r;
  logic [NCH-1:0][TW-1:0]  rem;
  logic [NCH-1:0][VW-1:0]  low;
  logic [NCH-1:0][TW:0]    tv;
  logic [NCH-1:0][TW:0]    dv;
  logic [NCH-1:0][TW-1:0]  rem_step;
  logic [NCH-1:0]          qbit;
  logic [NCH-1:0][VW-1:0]  quot;

  // restoring step per lane, rounding from the final remainder
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      tv[i]       = {rem[i], low[i][VW-1]};
      dv[i]       = tv[i] - {1'b0, den_r};
      qbit[i]     = (tv[i] >= {1'b0, den_r});
      rem_step[i] = qbit[i] ? dv[i][TW-1:0] : tv[i][TW-1:0];
      quot[i]     = low[i] + VW'({rem[i], 1'b0} >= {1'b0, den_r});
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= DCW'(VW);
        den_r <= req.den;
        for (int i = 0; i < NCH; i++) begin
          rem[i] <= req.mag[i][MW-1:VW];
          low[i] <= req.mag[i][VW-1:0];
        end
      end else if (busy) begin
        for (int i = 0; i < NCH; i++) begin
          rem[i] <= rem_step[i];
          low[i] <= {low[i][VW-2:0], qbit[i]};
        end
        cnt <= cnt - DCW'(1);
        if (cnt == DCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/kli_back.sv =====
module kli_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [kli_pkg::CNT_W-1:0] key_count,
  input  logic                     q_valid,
  input  kli_pkg::cmd_t            q_cmd,
  output logic                     q_pop,
  output logic                     ram_we,
  output logic [kli_pkg::AW-1:0]   ram_waddr,
  output kli_pkg::entry_t          ram_wdata,
  output logic [kli_pkg::AW-1:0]   ram_raddr,
  input  kli_pkg::entry_t          ram_rdata,
  output kli_pkg::div_req_t        div_req,
  input  kli_pkg::div_rsp_t        div_rsp,
  output logic                     result_valid,
  input  logic                     result_stall,
  output kli_pkg::res_t            result
);
  import kli_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LOLD = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]              state;
  logic [CW-1:0]           n;
  logic [CW-1:0]           idx;
  logic [CW-1:0]           chk_idx;
  logic [CW-1:0]           lo_idx;
  logic                    chk;
  logic                    hit;
  logic [TW-1:0]           qt;
  logic [TW-1:0]           t1;
  logic [TW-1:0]           num;
  logic [TW-1:0]           den;
  logic [NCH-1:0][VW-1:0]  v0;
  logic [NCH-1:0][VW-1:0]  v1;
  logic [NCH-1:0][VW-1:0]  diff;
  logic [NCH-1:0]          sgn;
  logic [NCH-1:0][VW-1:0]  res_v;
  logic [1:0]              res_status;

  assign n      = (32'(key_count) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count);
  assign hit    = (ram_rdata.t > qt);
  assign lo_idx = chk_idx - CW'(1);

  assign q_pop       = (state == ST_IDLE) && q_valid;
  assign ram_we      = q_pop && (q_cmd.kind == MODE_WRITE);
  assign ram_waddr   = q_cmd.addr;
  assign ram_wdata.t = q_cmd.t;
  assign ram_wdata.v = q_cmd.v;

  // lower neighbour is fetched the cycle the bracket is found
  always_comb begin
    ram_raddr = idx[AW-1:0];
    if ((state == ST_SCAN) && chk && hit && (chk_idx != '0)) begin
      ram_raddr = lo_idx[AW-1:0];
    end
  end

  always_comb begin
    div_req.start = (state == ST_MUL);
    div_req.den   = den;
    for (int i = 0; i < NCH; i++) begin
      div_req.mag[i] = MW'(diff[i]) * MW'(num);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      chk_idx      <= '0;
      chk          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid && (q_cmd.kind == MODE_QUERY)) begin
            qt <= q_cmd.t;
            if (n == '0) begin
              res_v      <= '0;
              res_status <= STATUS_EMPTY;
              state      <= ST_DONE;
            end else begin
              idx   <= '0;
              chk   <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (chk && hit) begin
            if (chk_idx == '0) begin
              res_v      <= ram_rdata.v;
              res_status <= STATUS_LOW;
              state      <= ST_DONE;
            end else begin
              t1    <= ram_rdata.t;
              v1    <= ram_rdata.v;
              state <= ST_LOLD;
            end
          end else if (chk && (chk_idx == n - CW'(1))) begin
            res_v      <= ram_rdata.v;
            res_status <= STATUS_HIGH;
            state      <= ST_DONE;
          end else begin
            chk     <= 1'b1;
            chk_idx <= idx;
            idx     <= idx + CW'(1);
          end
        end
        ST_LOLD: begin
          v0  <= ram_rdata.v;
          num <= qt - ram_rdata.t;
          den <= t1 - ram_rdata.t;
          for (int i = 0; i < NCH; i++) begin
            sgn[i]  <= (v1[i] < ram_rdata.v[i]);
            diff[i] <= (v1[i] < ram_rdata.v[i]) ? ram_rdata.v[i] - v1[i]
                                                : v1[i] - ram_rdata.v[i];
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            for (int i = 0; i < NCH; i++) begin
              res_v[i] <= sgn[i] ? v0[i] - div_rsp.quot[i] : v0[i] + div_rsp.quot[i];
            end
            res_status <= STATUS_INTERP;
            state      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid  <= 1'b1;
            result.out_x  <= res_v[0];
            result.out_y  <= res_v[1];
            result.out_z  <= res_v[2];
            result.status <= res_status;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/keyframe_linear_interpolator_core.sv =====
// a write item waits in the queue and reaches the table when the idle back end pops it
// an empty-table query skips the key scan, and a query clamped low or high skips the divider
// query time is set by the serial key scan (one table read per cycle) and the 16-step divider
// throughput: one item at a time in the back end, the two-entry queue takes items meanwhile
// reset (rst, synchronous): entry count to zero, queue, sequencer and result valid cleared
// keyframe table contents are not cleared
`include "keyframe_linear_interpolator_core_assert.svh"

module keyframe_linear_interpolator_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  kli_pkg::item_t            item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output kli_pkg::res_t             result,
  input  logic                      cfg_we,
  input  logic [kli_pkg::CNT_W-1:0] cfg_wdata
);
  import kli_pkg::*;

  logic [CNT_W-1:0] key_count;
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic [AW-1:0]    ram_raddr;
  entry_t           ram_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cfg_we) begin
      key_count <= cfg_wdata;
    end
  end

  kli_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd)
  );

  kli_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_KEYS)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kli_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  kli_back u_back (
    .clk          (clk),
    .rst          (rst),
    .key_count    (key_count),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `KLI_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divide restarted while busy")
  `KLI_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
  `KLI_ASSERT_IMP(a_we_from_write, ram_we, q_pop && q_cmd.kind == MODE_WRITE, "stray table write")
  `KLI_ASSERT_NXT(a_query_holds, q_pop && q_cmd.kind == MODE_QUERY, !q_pop, "query not held")

endmodule
